FILE: sv/usbets_pkg.sv
// ----------------------------------------------------------------------------
// usbets_pkg
// Shared types and codes for the USB endpoint transfer sequencer.
// ----------------------------------------------------------------------------
package usbets_pkg;

    typedef enum logic [2:0] {
        MODE_CONFIGURE = 3'd0,
        MODE_START     = 3'd1,
        MODE_DONE      = 3'd2,
        MODE_SETUP     = 3'd3,
        MODE_STALL     = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        KIND_CONFIGURED = 3'd0,
        KIND_ARMED      = 3'd1,
        KIND_COMPLETE   = 3'd2,
        KIND_SETUP_ACK  = 3'd3,
        KIND_STALLED    = 3'd4
    } t_kind;

    // One endpoint table entry.
    typedef struct packed {
        logic        configured;
        logic [6:0]  max_packet;
        logic        toggle;
        logic        active;
        logic [15:0] remaining;
        logic [15:0] transferred;
    } t_entry;

    // One latched command.
    typedef struct packed {
        t_mode       mode;
        logic [3:0]  ep_number;
        logic        ep_in;
        logic [6:0]  max_packet;
        logic [15:0] length;
        logic [9:0]  done_bytes;
    } t_cmd;

    // One result transaction.
    typedef struct packed {
        t_kind       kind;
        logic [3:0]  ep_number;
        logic        ep_in;
        logic [6:0]  buf_len;
        logic        buf_full;
        logic        buf_pid;
        logic        buf_last;
        logic [15:0] total_length;
        logic [10:0] buf_offset;
        logic        warn_active;
        logic        ep0_stall_arm;
    } t_result;

endpackage

FILE: sv/usbets_ep_ram.sv
// ----------------------------------------------------------------------------
// usbets_ep_ram
// Endpoint table: synchronous one-read one-write memory with per-entry
// valid bits, so an entry never written reads as all zero.
// ----------------------------------------------------------------------------
module usbets_ep_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  usbets_pkg::t_entry   i_wr_data,
    output usbets_pkg::t_entry   o_rd_data
);

    usbets_pkg::t_entry r_mem [DEPTH];
    usbets_pkg::t_entry r_rd_data;
    logic [DEPTH-1:0]   r_valid;
    logic               r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

FILE: sv/usbets_update.sv
// ----------------------------------------------------------------------------
// usbets_update
// Modify step of the read-modify-write: new entry and result transaction
// from one command and the entry read for it.
// ----------------------------------------------------------------------------
module usbets_update #(
    parameter int NUM_ENDPOINTS = 16,
    parameter int BUFFER_BYTES  = 64
) (
    input  usbets_pkg::t_cmd    i_cmd,
    input  usbets_pkg::t_entry  i_entry,
    output usbets_pkg::t_entry  o_entry,
    output usbets_pkg::t_result o_result
);

    localparam int InBase = NUM_ENDPOINTS * BUFFER_BYTES;

    logic [15:0] arm_rem;
    logic [6:0]  arm_len;
    logic [15:0] arm_left;
    logic [15:0] sum;
    logic [6:0]  mp_sat;
    logic [10:0] offset;
    logic        short_pkt;

    // Arm from the new length on start, from the stored count on continue.
    assign arm_rem  = (i_cmd.mode == usbets_pkg::MODE_START) ? i_cmd.length
                                                             : i_entry.remaining;
    assign arm_len  = (arm_rem > {9'b0, i_entry.max_packet}) ? i_entry.max_packet
                                                             : arm_rem[6:0];
    assign arm_left = arm_rem - {9'b0, arm_len};
    assign sum      = i_entry.transferred + {6'b0, i_cmd.done_bytes};
    assign short_pkt = {3'b0, i_cmd.done_bytes} < {6'b0, i_entry.max_packet} ? 1'b1
                                                                               : 1'b0;
    assign mp_sat   = (i_cmd.max_packet > 7'(BUFFER_BYTES)) ? 7'(BUFFER_BYTES)
                                                            : i_cmd.max_packet;
    // EP0 uses its fixed buffer; IN endpoints sit above all OUT buffers.
    assign offset   = (i_cmd.ep_number == 4'd0) ? 11'd0
                    : 11'((int'(i_cmd.ep_number) - 1) * BUFFER_BYTES
                          + (i_cmd.ep_in ? InBase : 0));

    always_comb begin
        o_entry            = i_entry;
        o_result           = '0;
        o_result.ep_number = i_cmd.ep_number;
        o_result.ep_in     = i_cmd.ep_in;
        unique case (i_cmd.mode)
            usbets_pkg::MODE_CONFIGURE: begin
                o_entry.configured  = 1'b1;
                o_entry.max_packet  = mp_sat;
                o_entry.toggle      = 1'b0;
                o_result.kind       = usbets_pkg::KIND_CONFIGURED;
                o_result.buf_offset = offset;
            end
            usbets_pkg::MODE_START: begin
                o_result.warn_active = i_entry.active;
                o_entry.active       = 1'b1;
                o_entry.transferred  = 16'd0;
                o_entry.remaining    = arm_left;
                o_entry.toggle       = ~i_entry.toggle;
                o_result.kind        = usbets_pkg::KIND_ARMED;
                o_result.buf_len     = arm_len;
                o_result.buf_full    = i_cmd.ep_in;
                o_result.buf_pid     = i_entry.toggle;
                o_result.buf_last    = (arm_left == 16'd0);
            end
            usbets_pkg::MODE_DONE: begin
                if (!i_entry.active) begin
                    o_result.kind         = usbets_pkg::KIND_COMPLETE;
                    o_result.total_length = i_entry.transferred;
                end else if (short_pkt || i_entry.remaining == 16'd0) begin
                    o_entry.transferred   = sum;
                    o_entry.remaining     = 16'd0;
                    o_entry.active        = 1'b0;
                    o_result.kind         = usbets_pkg::KIND_COMPLETE;
                    o_result.total_length = sum;
                end else begin
                    o_entry.transferred = sum;
                    o_entry.remaining   = arm_left;
                    o_entry.toggle      = ~i_entry.toggle;
                    o_result.kind       = usbets_pkg::KIND_ARMED;
                    o_result.buf_len    = arm_len;
                    o_result.buf_full   = i_cmd.ep_in;
                    o_result.buf_pid    = i_entry.toggle;
                    o_result.buf_last   = (arm_left == 16'd0);
                end
            end
            usbets_pkg::MODE_SETUP: begin
                o_entry.toggle = 1'b1;
                o_result       = '0;
                o_result.kind  = usbets_pkg::KIND_SETUP_ACK;
            end
            usbets_pkg::MODE_STALL: begin
                o_result.kind          = usbets_pkg::KIND_STALLED;
                o_result.ep0_stall_arm = (i_cmd.ep_number == 4'd0);
            end
            default: begin
                o_entry  = i_entry;
                o_result = '0;
            end
        endcase
    end

endmodule

FILE: sv/usb_endpoint_transfer_sequencer_unit.sv
// ----------------------------------------------------------------------------
// usb_endpoint_transfer_sequencer_unit
// Per-endpoint USB device transfer sequencer: packet segmentation and
// DATA0/DATA1 toggle tracking over a table of endpoint entries.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  ---------------------------------
// command   in         start && !busy       i_mode .. i_done_bytes
// result    out        o_strobe, one cycle  o_result_kind .. o_ep0_stall_arm
//
// Sequence: a command is taken at an edge with start high and busy low; its
// entry is read from the endpoint table at that edge. The next cycle
// modifies the entry and writes it back, and the result shows in the
// cycle after, while busy is already low. A setup command rewrites both
// EP0 entries in turn, EP0 OUT first and then EP0 IN. An ignored command
// (unknown mode, endpoint out of range) gives no result and leaves busy
// low. Reset clears the table's valid bits at once; no clearing pass. The
// receiver cannot stall; each result is a one-cycle transaction.
// ----------------------------------------------------------------------------
module usb_endpoint_transfer_sequencer_unit #(
    parameter int NUM_ENDPOINTS = 16,
    parameter int BUFFER_BYTES  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_mode,
    input  logic [3:0]  i_ep_number,
    input  logic        i_ep_in,
    input  logic [6:0]  i_max_packet,
    input  logic [15:0] i_length,
    input  logic [9:0]  i_done_bytes,
    output logic        o_strobe,
    output logic [2:0]  o_result_kind,
    output logic [3:0]  o_out_ep_number,
    output logic        o_out_ep_in,
    output logic [6:0]  o_buf_len,
    output logic        o_buf_full,
    output logic        o_buf_pid,
    output logic        o_buf_last,
    output logic [15:0] o_total_length,
    output logic [10:0] o_buf_offset,
    output logic        o_warn_active,
    output logic        o_ep0_stall_arm
);

    localparam int Depth = NUM_ENDPOINTS * 2;
    localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_SETUP1 = 3'b100
    } t_state;

    t_state r_state, n_state;
    usbets_pkg::t_cmd    r_cmd;
    usbets_pkg::t_cmd    in_cmd;
    logic [AW-1:0]       r_addr;
    usbets_pkg::t_result r_res;
    logic                r_strobe, n_strobe;

    logic                accept;
    logic                ignore;
    logic                is_setup;
    logic [4:0]          idx_full;
    logic [AW-1:0]       in_addr;
    logic                rd_en, wr_en;
    logic [AW-1:0]       rd_addr, wr_addr;
    usbets_pkg::t_entry  rd_data, wr_data;
    usbets_pkg::t_result upd_res;

    // Decode the incoming command.
    assign in_cmd.mode       = usbets_pkg::t_mode'(i_mode);
    assign in_cmd.ep_number  = i_ep_number;
    assign in_cmd.ep_in      = i_ep_in;
    assign in_cmd.max_packet = i_max_packet;
    assign in_cmd.length     = i_length;
    assign in_cmd.done_bytes = i_done_bytes;

    assign busy     = !r_state[0];
    assign accept   = start && !busy;
    assign idx_full = {i_ep_number, i_ep_in};
    assign in_addr  = idx_full[AW-1:0];
    // Setup does not look at the endpoint number; every other mode drops an
    // endpoint beyond the table, and modes above stall are dropped too.
    assign ignore   = (i_mode > 3'(usbets_pkg::MODE_STALL))
                   || ((in_cmd.mode != usbets_pkg::MODE_SETUP)
                       && ({1'b0, i_ep_number} >= 5'(NUM_ENDPOINTS)));
    assign is_setup = (r_cmd.mode == usbets_pkg::MODE_SETUP);

    // Table port control: read on accept, write back in the modify cycle.
    // A setup reads EP0 OUT first, then EP0 IN while writing EP0 OUT.
    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = in_addr;
        wr_en    = 1'b0;
        wr_addr  = r_addr;
        unique case (r_state)
            S_IDLE: begin
                rd_en   = accept;
                rd_addr = (in_cmd.mode == usbets_pkg::MODE_SETUP) ? '0 : in_addr;
                if (accept && !ignore) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                wr_en = 1'b1;
                if (is_setup) begin
                    wr_addr = '0;
                    rd_en   = 1'b1;
                    rd_addr = AW'(1);
                    n_state = S_SETUP1;
                end else begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_SETUP1: begin
                wr_en    = 1'b1;
                wr_addr  = AW'(1);
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // Hold the command and its entry address for the modify cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= in_cmd;
            r_addr <= in_addr;
        end
        if (n_strobe) begin
            r_res <= upd_res;
        end
    end

    usbets_ep_ram #(
        .DEPTH (Depth),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    usbets_update #(
        .NUM_ENDPOINTS (NUM_ENDPOINTS),
        .BUFFER_BYTES  (BUFFER_BYTES)
    ) u_update (
        .i_cmd    (r_cmd),
        .i_entry  (rd_data),
        .o_entry  (wr_data),
        .o_result (upd_res)
    );

    // Drive the result transaction from the output register.
    assign o_strobe        = r_strobe;
    assign o_result_kind   = r_res.kind;
    assign o_out_ep_number = r_res.ep_number;
    assign o_out_ep_in     = r_res.ep_in;
    assign o_buf_len       = r_res.buf_len;
    assign o_buf_full      = r_res.buf_full;
    assign o_buf_pid       = r_res.buf_pid;
    assign o_buf_last      = r_res.buf_last;
    assign o_total_length  = r_res.total_length;
    assign o_buf_offset    = r_res.buf_offset;
    assign o_warn_active   = r_res.warn_active;
    assign o_ep0_stall_arm = r_res.ep0_stall_arm;

endmodule

FILE: dv/tb_usb_endpoint_transfer_sequencer_unit.sv
// ----------------------------------------------------------------------------
// tb_usb_endpoint_transfer_sequencer_unit
// Self-checking bench for the USB endpoint transfer sequencer. A short
// directed table covers field extremes, every mode and the corner cases.
// Random transfers follow: configure, start and a chain of buffer-done
// transactions on random endpoints, mixed with setup, stall and noise.
// Each result is checked field by field against a hand-typed expectation
// or an in-bench endpoint table model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_usb_endpoint_transfer_sequencer_unit;

    localparam int NUM_EP       = 16;
    localparam int BUF_BYTES    = 64;
    localparam int NUM_ENTRIES  = NUM_EP * 2;
    localparam int RANDOM_ITEMS = 1100;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 400000;

    // Mode codes the block does not decode; it must drop these silently.
    localparam logic [2:0] MODE_RSVD_5 = 3'd5;
    localparam logic [2:0] MODE_RSVD_6 = 3'd6;
    localparam logic [2:0] MODE_RSVD_7 = 3'd7;

    // One stimulus row: a command plus, optionally, a hand-typed result.
    typedef struct {
        usbets_pkg::t_cmd    cmd;
        bit                  typed;
        bit                  has_result;
        usbets_pkg::t_result res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_mode;
    logic [3:0]  i_ep_number;
    logic        i_ep_in;
    logic [6:0]  i_max_packet;
    logic [15:0] i_length;
    logic [9:0]  i_done_bytes;
    logic        o_strobe;
    logic [2:0]  o_result_kind;
    logic [3:0]  o_out_ep_number;
    logic        o_out_ep_in;
    logic [6:0]  o_buf_len;
    logic        o_buf_full;
    logic        o_buf_pid;
    logic        o_buf_last;
    logic [15:0] o_total_length;
    logic [10:0] o_buf_offset;
    logic        o_warn_active;
    logic        o_ep0_stall_arm;

    // Hand-typed expectation travelling alongside the command on the pins.
    bit                  typed_now;
    bit                  typed_has;
    usbets_pkg::t_result typed_report;

    usbets_pkg::t_entry  ep_model [NUM_ENTRIES] = '{default: '0};
    usbets_pkg::t_result pending_reports [$];
    int                  mismatch_count = 0;
    int                  accepted_items;
    int                  cycle_count = 0;

    // Stimulus-side view of each endpoint's packet size, used only to shape
    // realistic buffer-done byte counts.
    int          drv_mp    [NUM_ENTRIES];
    bit          drv_known [NUM_ENTRIES];

    usb_endpoint_transfer_sequencer_unit #(
        .NUM_ENDPOINTS (NUM_EP),
        .BUFFER_BYTES  (BUF_BYTES)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_ep_number     (i_ep_number),
        .i_ep_in         (i_ep_in),
        .i_max_packet    (i_max_packet),
        .i_length        (i_length),
        .i_done_bytes    (i_done_bytes),
        .o_strobe        (o_strobe),
        .o_result_kind   (o_result_kind),
        .o_out_ep_number (o_out_ep_number),
        .o_out_ep_in     (o_out_ep_in),
        .o_buf_len       (o_buf_len),
        .o_buf_full      (o_buf_full),
        .o_buf_pid       (o_buf_pid),
        .o_buf_last      (o_buf_last),
        .o_total_length  (o_total_length),
        .o_buf_offset    (o_buf_offset),
        .o_warn_active   (o_warn_active),
        .o_ep0_stall_arm (o_ep0_stall_arm)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Endpoint table model
    // ------------------------------------------------------------------------

    // Arm the next buffer of an active transfer: take at most one maximum
    // packet off the remaining count, report the PID and flip the toggle.
    function automatic void load_packet(input int unsigned e, input logic dir,
                                        inout usbets_pkg::t_result r);
        logic [15:0] seg;
        seg = (ep_model[e].remaining > {9'd0, ep_model[e].max_packet})
            ? {9'd0, ep_model[e].max_packet} : ep_model[e].remaining;
        ep_model[e].remaining = ep_model[e].remaining - seg;
        r.kind     = usbets_pkg::KIND_ARMED;
        r.buf_len  = seg[6:0];
        r.buf_full = dir;
        r.buf_pid  = ep_model[e].toggle;
        ep_model[e].toggle = ~ep_model[e].toggle;
        r.buf_last = (ep_model[e].remaining == 16'd0);
    endfunction

    // Apply one command to the table; return 1 when it produces a result.
    function automatic bit advance_endpoints(input usbets_pkg::t_cmd c,
                                             output usbets_pkg::t_result r);
        int unsigned e;
        logic [6:0]  mp;
        r = '0;
        e = c.ep_number * 2 + c.ep_in;
        if (c.mode == usbets_pkg::MODE_SETUP) begin
            // Setup forces both EP0 directions to DATA1.
            ep_model[0].toggle = 1'b1;
            ep_model[1].toggle = 1'b1;
            r.kind = usbets_pkg::KIND_SETUP_ACK;
            return 1'b1;
        end
        if (c.mode > usbets_pkg::MODE_STALL || c.ep_number >= NUM_EP) begin
            return 1'b0;
        end
        r.ep_number = c.ep_number;
        r.ep_in     = c.ep_in;
        case (c.mode)
            usbets_pkg::MODE_CONFIGURE: begin
                mp = (c.max_packet > BUF_BYTES) ? 7'(BUF_BYTES) : c.max_packet;
                ep_model[e].configured = 1'b1;
                ep_model[e].max_packet = mp;
                ep_model[e].toggle     = 1'b0;
                // EP0 keeps its fixed buffer; others index into the data area.
                if (c.ep_number != 4'd0) begin
                    r.buf_offset = 11'((c.ep_number - 1) * BUF_BYTES
                                       + NUM_EP * BUF_BYTES * c.ep_in);
                end
                r.kind = usbets_pkg::KIND_CONFIGURED;
            end
            usbets_pkg::MODE_START: begin
                r.warn_active = ep_model[e].active;
                ep_model[e].active      = 1'b1;
                ep_model[e].transferred = 16'd0;
                ep_model[e].remaining   = c.length;
                load_packet(e, c.ep_in, r);
            end
            usbets_pkg::MODE_DONE: begin
                if (!ep_model[e].active) begin
                    // Done on an idle endpoint reports the stale total.
                    r.kind         = usbets_pkg::KIND_COMPLETE;
                    r.total_length = ep_model[e].transferred;
                end else begin
                    ep_model[e].transferred =
                        ep_model[e].transferred + {6'd0, c.done_bytes};
                    if (c.done_bytes < {3'd0, ep_model[e].max_packet}) begin
                        ep_model[e].remaining = 16'd0;
                    end
                    if (ep_model[e].remaining == 16'd0) begin
                        ep_model[e].active = 1'b0;
                        r.kind         = usbets_pkg::KIND_COMPLETE;
                        r.total_length = ep_model[e].transferred;
                    end else begin
                        load_packet(e, c.ep_in, r);
                    end
                end
            end
            default: begin
                r.kind          = usbets_pkg::KIND_STALLED;
                r.ep0_stall_arm = (c.ep_number == 4'd0);
            end
        endcase
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $realtime, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Sample both channels at the edge: compare any result transaction
    // against the oldest expectation, then model any accepted command.
    always @(posedge i_clk) begin
        usbets_pkg::t_result seen;
        usbets_pkg::t_result want;
        usbets_pkg::t_result modeled;
        usbets_pkg::t_cmd    c;
        bit                  made;
        if (i_rst_n) begin
            if (o_strobe) begin
                seen.kind          = usbets_pkg::t_kind'(o_result_kind);
                seen.ep_number     = o_out_ep_number;
                seen.ep_in         = o_out_ep_in;
                seen.buf_len       = o_buf_len;
                seen.buf_full      = o_buf_full;
                seen.buf_pid       = o_buf_pid;
                seen.buf_last      = o_buf_last;
                seen.total_length  = o_total_length;
                seen.buf_offset    = o_buf_offset;
                seen.warn_active   = o_warn_active;
                seen.ep0_stall_arm = o_ep0_stall_arm;
                if (pending_reports.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d ep %0d",
                             $realtime, o_result_kind, o_out_ep_number);
                    mismatch_count++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("result_kind", want.kind, seen.kind);
                    check_field("out_ep_number", want.ep_number, seen.ep_number);
                    check_field("out_ep_in", want.ep_in, seen.ep_in);
                    check_field("buf_len", want.buf_len, seen.buf_len);
                    check_field("buf_full", want.buf_full, seen.buf_full);
                    check_field("buf_pid", want.buf_pid, seen.buf_pid);
                    check_field("buf_last", want.buf_last, seen.buf_last);
                    check_field("total_length", want.total_length, seen.total_length);
                    check_field("buf_offset", want.buf_offset, seen.buf_offset);
                    check_field("warn_active", want.warn_active, seen.warn_active);
                    check_field("ep0_stall_arm", want.ep0_stall_arm,
                                seen.ep0_stall_arm);
                end
            end
            if (start && !busy) begin
                c.mode       = usbets_pkg::t_mode'(i_mode);
                c.ep_number  = i_ep_number;
                c.ep_in      = i_ep_in;
                c.max_packet = i_max_packet;
                c.length     = i_length;
                c.done_bytes = i_done_bytes;
                // Always advance the model; a typed row only overrides the
                // expectation it queues.
                made = advance_endpoints(c, modeled);
                if (typed_now) begin
                    if (typed_has) begin
                        pending_reports.push_back(typed_report);
                    end
                end else if (made) begin
                    pending_reports.push_back(modeled);
                end
            end
        end
    end

    // Hard stop if the run hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    function automatic usbets_pkg::t_cmd mk_cmd(input logic [2:0] m,
                                                input int unsigned ep,
                                                input int unsigned dir,
                                                input int unsigned mp,
                                                input int unsigned len,
                                                input int unsigned done);
        usbets_pkg::t_cmd c;
        c.mode       = usbets_pkg::t_mode'(m);
        c.ep_number  = 4'(ep);
        c.ep_in      = 1'(dir);
        c.max_packet = 7'(mp);
        c.length     = 16'(len);
        c.done_bytes = 10'(done);
        return c;
    endfunction

    function automatic usbets_pkg::t_result mk_res(input usbets_pkg::t_kind k,
                                                   input int unsigned ep,
                                                   input int unsigned dir,
                                                   input int unsigned len,
                                                   input int unsigned full,
                                                   input int unsigned pid,
                                                   input int unsigned last,
                                                   input int unsigned total,
                                                   input int unsigned offset,
                                                   input int unsigned warn,
                                                   input int unsigned stall);
        usbets_pkg::t_result r;
        r.kind          = k;
        r.ep_number     = 4'(ep);
        r.ep_in         = 1'(dir);
        r.buf_len       = 7'(len);
        r.buf_full      = 1'(full);
        r.buf_pid       = 1'(pid);
        r.buf_last      = 1'(last);
        r.total_length  = 16'(total);
        r.buf_offset    = 11'(offset);
        r.warn_active   = 1'(warn);
        r.ep0_stall_arm = 1'(stall);
        return r;
    endfunction

    function automatic t_row typed_row(input usbets_pkg::t_cmd c, input bit has,
                                       input usbets_pkg::t_result r);
        t_row row;
        row.cmd        = c;
        row.typed      = 1'b1;
        row.has_result = has;
        row.res        = r;
        return row;
    endfunction

    function automatic t_row open_row(input usbets_pkg::t_cmd c);
        t_row row;
        row.cmd        = c;
        row.typed      = 1'b0;
        row.has_result = 1'b0;
        row.res        = '0;
        return row;
    endfunction

    // Present one command, hold it until the block takes it, then, with a
    // chance of idle_pct percent, drop start and idle the command channel.
    task automatic issue(input t_row r, input int idle_pct);
        start        <= 1'b1;
        i_mode       <= r.cmd.mode;
        i_ep_number  <= r.cmd.ep_number;
        i_ep_in      <= r.cmd.ep_in;
        i_max_packet <= r.cmd.max_packet;
        i_length     <= r.cmd.length;
        i_done_bytes <= r.cmd.done_bytes;
        typed_now    <= r.typed;
        typed_has    <= r.has_result;
        typed_report <= r.res;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (r.cmd.mode <= usbets_pkg::MODE_STALL) begin
            accepted_items++;
        end
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
    endtask

    initial begin
        t_row        directed_rows [$];
        int          idle_pct;
        int          pick;
        int          ep;
        int          dir;
        int          e;
        int          mp;
        int          mp_req;
        int          len;
        int          rem;
        int          armed;
        int          done;
        int          cap;
        int          nbuf;
        bit          long_run;
        bit          finished;

        // Drive every input to a known value before the first edge.
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_mode         = usbets_pkg::MODE_CONFIGURE;
        i_ep_number    = '0;
        i_ep_in        = 1'b0;
        i_max_packet   = '0;
        i_length       = '0;
        i_done_bytes   = '0;
        typed_now      = 1'b0;
        typed_has      = 1'b0;
        typed_report   = '0;
        accepted_items = 0;

        // Directed table: typed rows where the answer is plain, model rows
        // where it depends on accumulated state.
        directed_rows.push_back(typed_row(
            mk_cmd(usbets_pkg::MODE_STALL, 0, 0, 0, 0, 0), 1'b1,
            mk_res(usbets_pkg::KIND_STALLED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1)));
        directed_rows.push_back(typed_row(
            mk_cmd(usbets_pkg::MODE_STALL, 15, 1, 127, 65535, 1023), 1'b1,
            mk_res(usbets_pkg::KIND_STALLED, 15, 1, 0, 0, 0, 0, 0, 0, 0, 0)));
        // Buffer done on an idle endpoint: complete with the stored total.
        directed_rows.push_back(typed_row(
            mk_cmd(usbets_pkg::MODE_DONE, 3, 0, 0, 0, 1023), 1'b1,
            mk_res(usbets_pkg::KIND_COMPLETE, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
        // Start on an unconfigured endpoint arms a zero-length buffer.
        directed_rows.push_back(typed_row(
            mk_cmd(usbets_pkg::MODE_START, 5, 1, 0, 100, 0), 1'b1,
            mk_res(usbets_pkg::KIND_ARMED, 5, 1, 0, 1, 0, 0, 0, 0, 0, 0)));
        // Restart while active raises the warning; zero length is last.
        directed_rows.push_back(typed_row(
            mk_cmd(usbets_pkg::MODE_START, 5, 1, 0, 0, 0), 1'b1,
            mk_res(usbets_pkg::KIND_ARMED, 5, 1, 0, 1, 1, 1, 0, 0, 1, 0)));
        // Oversized packet size saturates.
        directed_rows.push_back(typed_row(
            mk_cmd(usbets_pkg::MODE_CONFIGURE, 0, 0, 127, 0, 0), 1'b1,
            mk_res(usbets_pkg::KIND_CONFIGURED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(typed_row(
            mk_cmd(usbets_pkg::MODE_CONFIGURE, 15, 1, 64, 0, 0), 1'b1,
            mk_res(usbets_pkg::KIND_CONFIGURED, 15, 1, 0, 0, 0, 0, 0, 1920, 0, 0)));
        directed_rows.push_back(typed_row(
            mk_cmd(usbets_pkg::MODE_CONFIGURE, 1, 0, 0, 0, 0), 1'b1,
            mk_res(usbets_pkg::KIND_CONFIGURED, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(typed_row(
            mk_cmd(usbets_pkg::MODE_CONFIGURE, 1, 1, 8, 0, 0), 1'b1,
            mk_res(usbets_pkg::KIND_CONFIGURED, 1, 1, 0, 0, 0, 0, 0, 1024, 0, 0)));
        // Undecoded modes are dropped without a result.
        directed_rows.push_back(typed_row(mk_cmd(MODE_RSVD_5, 2, 0, 0, 0, 0), 1'b0, '0));
        directed_rows.push_back(typed_row(mk_cmd(MODE_RSVD_7, 15, 1, 127, 65535, 1023),
            1'b0, '0));
        // Setup acks with zeroed fields whatever the other inputs hold.
        directed_rows.push_back(typed_row(
            mk_cmd(usbets_pkg::MODE_SETUP, 9, 1, 127, 65535, 1023), 1'b1,
            mk_res(usbets_pkg::KIND_SETUP_ACK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(open_row(mk_cmd(usbets_pkg::MODE_START, 0, 0, 0, 65535, 0)));
        directed_rows.push_back(open_row(mk_cmd(usbets_pkg::MODE_DONE, 0, 0, 0, 0, 64)));
        directed_rows.push_back(open_row(mk_cmd(usbets_pkg::MODE_START, 0, 0, 0, 10, 0)));
        directed_rows.push_back(open_row(mk_cmd(usbets_pkg::MODE_DONE, 0, 0, 0, 0, 10)));
        directed_rows.push_back(typed_row(
            mk_cmd(usbets_pkg::MODE_CONFIGURE, 2, 0, 16, 0, 0), 1'b1,
            mk_res(usbets_pkg::KIND_CONFIGURED, 2, 0, 0, 0, 0, 0, 0, 64, 0, 0)));
        directed_rows.push_back(open_row(mk_cmd(usbets_pkg::MODE_START, 2, 0, 0, 32, 0)));
        directed_rows.push_back(open_row(mk_cmd(usbets_pkg::MODE_DONE, 2, 0, 0, 0, 16)));
        directed_rows.push_back(open_row(mk_cmd(usbets_pkg::MODE_DONE, 2, 0, 0, 0, 16)));
        directed_rows.push_back(open_row(mk_cmd(usbets_pkg::MODE_START, 1, 1, 0, 0, 0)));
        directed_rows.push_back(open_row(mk_cmd(usbets_pkg::MODE_DONE, 1, 1, 0, 0, 1023)));
        directed_rows.push_back(open_row(mk_cmd(usbets_pkg::MODE_DONE, 1, 1, 0, 0, 0)));
        directed_rows.push_back(typed_row(mk_cmd(MODE_RSVD_6, 0, 0, 0, 0, 0), 1'b0, '0));

        // Hold reset, then release it once for the whole run.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) issue(directed_rows[k], 8);

        accepted_items = 0;
        while (accepted_items < RANDOM_ITEMS) begin
            // Sender idling by thirds: light, heavy, none.
            if (accepted_items < RANDOM_ITEMS / 3) begin
                idle_pct = 8;
            end else if (accepted_items < 2 * RANDOM_ITEMS / 3) begin
                idle_pct = 59;
            end else begin
                idle_pct = 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // Noise: any mode code, including undecoded ones.
                issue(open_row(mk_cmd(3'($urandom_range(0, 7)), $urandom_range(0, 15),
                                      $urandom_range(0, 1), $urandom_range(0, 127),
                                      $urandom_range(0, 65535), $urandom_range(0, 1023))),
                      idle_pct);
            end else if (pick < 12) begin
                issue(open_row(mk_cmd(usbets_pkg::MODE_SETUP, $urandom_range(0, 15),
                                      $urandom_range(0, 1), $urandom_range(0, 127),
                                      $urandom_range(0, 65535),
                                      $urandom_range(0, 1023))), idle_pct);
            end else if (pick < 16) begin
                issue(open_row(mk_cmd(usbets_pkg::MODE_STALL, $urandom_range(0, 15),
                                      $urandom_range(0, 1), 0, 0, 0)), idle_pct);
            end else begin
                // Well-formed transfer: optional configure, start, then a
                // chain of buffer-done transactions until short or empty.
                ep  = $urandom_range(0, 15);
                dir = $urandom_range(0, 1);
                e   = ep * 2 + dir;
                // An occasional long run with tiny packets and oversized
                // byte counts pushes the transferred total past 16 bits.
                long_run = ($urandom_range(0, 39) == 0);
                if (!drv_known[e] || long_run || $urandom_range(0, 99) < 30) begin
                    pick = $urandom_range(0, 9);
                    if (long_run) begin
                        mp_req = $urandom_range(1, 8);
                    end else if (pick == 0) begin
                        mp_req = 0;
                    end else if (pick == 1) begin
                        mp_req = $urandom_range(65, 127);
                    end else begin
                        mp_req = $urandom_range(1, 64);
                    end
                    issue(open_row(mk_cmd(usbets_pkg::MODE_CONFIGURE, ep, dir, mp_req,
                                          0, 0)), idle_pct);
                    drv_mp[e]    = (mp_req > BUF_BYTES) ? BUF_BYTES : mp_req;
                    drv_known[e] = 1'b1;
                end
                mp   = drv_mp[e];
                pick = $urandom_range(0, 99);
                if (long_run || pick >= 85) begin
                    len = $urandom_range(0, 65535);
                end else if (pick < 60) begin
                    len = $urandom_range(0, 3 * mp + 5);
                end else begin
                    len = $urandom_range(0, 1023);
                end
                issue(open_row(mk_cmd(usbets_pkg::MODE_START, ep, dir,
                                      $urandom_range(0, 127), len,
                                      $urandom_range(0, 1023))), idle_pct);
                rem = len;
                if (long_run) begin
                    cap = 150;
                end else if ($urandom_range(0, 9) == 0) begin
                    // Abandon early; a later start finds the endpoint active.
                    cap = $urandom_range(0, 2);
                end else begin
                    cap = 24;
                end
                nbuf     = 0;
                finished = 1'b0;
                while (!finished && nbuf < cap) begin
                    armed = (rem < mp) ? rem : mp;
                    rem   = rem - armed;
                    pick  = $urandom_range(0, 99);
                    if (long_run) begin
                        done = $urandom_range(mp, 1023);
                    end else if (pick < 65) begin
                        done = armed;
                    end else if (pick < 80) begin
                        done = (mp > 0) ? $urandom_range(0, mp - 1) : 0;
                    end else if (pick < 90) begin
                        done = $urandom_range(0, 1023);
                    end else begin
                        done = $urandom_range(mp, 1023);
                    end
                    issue(open_row(mk_cmd(usbets_pkg::MODE_DONE, ep, dir,
                                          $urandom_range(0, 127),
                                          $urandom_range(0, 65535), done)), idle_pct);
                    nbuf++;
                    finished = (done < mp) || (rem == 0);
                end
            end
        end

        // Release the command channel and drain outstanding results.
        start <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/usbets_pkg.sv
sv/usbets_ep_ram.sv
sv/usbets_update.sv
sv/usb_endpoint_transfer_sequencer_unit.sv
dv/tb_usb_endpoint_transfer_sequencer_unit.sv
